// ===== design/euler_rotate_isometric_project_defines.svh =====
`ifndef EULER_ROTATE_ISOMETRIC_PROJECT_DEFINES_SVH
`define EULER_ROTATE_ISOMETRIC_PROJECT_DEFINES_SVH

// same-cycle implication on the block clock, quiet while in reset
`define ERIP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the block clock, quiet while in reset
`define ERIP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/erip_pkg.sv =====
package erip_pkg;

    localparam int COORD_WIDTH_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;

    localparam int COEF_W     = 16;
    localparam int OFFS_W     = 17;
    localparam int OUT_W      = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_COS_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SIN_X = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COS_Y = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SIN_Y = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_COS_Z = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SIN_Z = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_OFF_X = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_OFF_Y = CFG_IDX_W'(7);

    // cos(0.5) and sin(0.5) with 32 fraction bits
    localparam logic [31:0] COS_HALF_Q32 = 32'd3769188403;
    localparam logic [31:0] SIN_HALF_Q32 = 32'd2059117009;

    localparam int STG_XY     = 5;
    localparam int STG_Z      = 3;
    localparam int STG_PROJ   = 5;
    localparam int PIPE_DEPTH = STG_XY + STG_Z + STG_PROJ;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    typedef struct packed {
        logic signed [COEF_W-1:0] cos_x;
        logic signed [COEF_W-1:0] sin_x;
        logic signed [COEF_W-1:0] cos_y;
        logic signed [COEF_W-1:0] sin_y;
        logic signed [COEF_W-1:0] cos_z;
        logic signed [COEF_W-1:0] sin_z;
    } t_coef;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int imin(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // width of y1 and z1 after the x rotation
    function automatic int y1_w(input int cw);
        return cw + COEF_W + 1;
    endfunction

    // width of x2 and z2 after the y rotation and rounding
    function automatic int x2_w(input int cw, input int fb);
        return imax(cw + COEF_W + fb, y1_w(cw) + COEF_W) + 1 - fb + 1;
    endfunction

    // width of x3 and y3 after the z rotation, sums wrap at 64 bits
    function automatic int x3_w(input int cw, input int fb);
        return imin(imax(x2_w(cw, fb), y1_w(cw)) + COEF_W + 1, 64) - fb + 1;
    endfunction

    // constant rounded from 32 to fb fraction bits
    function automatic logic [31:0] const_frac(input logic [31:0] q32, input int fb);
        logic [32:0] t;
        int          d;
        d = 32 - fb;
        t = {1'b0, q32} + (33'd1 << (d - 1));
        return 32'(t >> d);
    endfunction

endpackage

// ===== design/erip_rot_xy.sv =====
module erip_rot_xy #(
    parameter int COORD_W = erip_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_B  = erip_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic signed [COORD_W-1:0]                 i_x,
    input  logic signed [COORD_W-1:0]                 i_y,
    input  logic signed [COORD_W-1:0]                 i_z,
    input  erip_pkg::t_coef                           i_coef,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic signed [erip_pkg::x2_w(COORD_W, FRAC_B)-1:0] o_x2,
    output logic signed [erip_pkg::x2_w(COORD_W, FRAC_B)-1:0] o_z2,
    output logic signed [erip_pkg::y1_w(COORD_W)-1:0] o_y1
);
    import erip_pkg::*;

    localparam int N    = STG_XY;
    localparam int PW   = COORD_W + COEF_W;
    localparam int Y1W  = y1_w(COORD_W);
    localparam int QW   = Y1W + COEF_W;
    localparam int S1   = imax(PW + FRAC_B, QW) + 1;
    localparam int RW   = S1 + 1;
    localparam int X2W  = x2_w(COORD_W, FRAC_B);
    localparam longint HALF = longint'(1) <<< (FRAC_B - 1);

    logic [N-1:0] r_v;
    logic [N:0]   w_en;

    logic signed [PW-1:0]  r_ycx, r_zsx, r_ysx, r_zcx, r_xcy0, r_xsy0;
    logic signed [PW-1:0]  r_xcy1, r_xsy1, r_xcy2, r_xsy2;
    logic signed [Y1W-1:0] r_y1_1, r_z1, r_y1_2, r_y1_3, r_y1_4;
    logic signed [QW-1:0]  r_z1sy, r_z1cy;
    logic signed [S1-1:0]  r_sx2, r_sz2;
    logic signed [RW-1:0]  n_rx, n_rz;
    logic signed [X2W-1:0] r_x2, r_z2;

    always_comb begin
        w_en[N] = i_ready;
        for (int k = N - 1; k >= 0; k--) begin
            w_en[k] = ~r_v[k] | w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // half away from zero: add half, less one when negative, then floor
    always_comb begin
        n_rx = RW'(r_sx2) + RW'(HALF) - RW'({1'b0, r_sx2[S1-1]});
        n_rz = RW'(r_sz2) + RW'(HALF) - RW'({1'b0, r_sz2[S1-1]});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_ycx  <= PW'(i_y) * PW'(i_coef.cos_x);
            r_zsx  <= PW'(i_z) * PW'(i_coef.sin_x);
            r_ysx  <= PW'(i_y) * PW'(i_coef.sin_x);
            r_zcx  <= PW'(i_z) * PW'(i_coef.cos_x);
            r_xcy0 <= PW'(i_x) * PW'(i_coef.cos_y);
            r_xsy0 <= PW'(i_x) * PW'(i_coef.sin_y);
        end
        if (w_en[1]) begin
            r_y1_1 <= Y1W'(r_ycx) - Y1W'(r_zsx);
            r_z1   <= Y1W'(r_ysx) + Y1W'(r_zcx);
            r_xcy1 <= r_xcy0;
            r_xsy1 <= r_xsy0;
        end
        if (w_en[2]) begin
            r_z1sy <= QW'(r_z1) * QW'(i_coef.sin_y);
            r_z1cy <= QW'(r_z1) * QW'(i_coef.cos_y);
            r_xcy2 <= r_xcy1;
            r_xsy2 <= r_xsy1;
            r_y1_2 <= r_y1_1;
        end
        if (w_en[3]) begin
            r_sx2  <= (S1'(r_xcy2) <<< FRAC_B) + S1'(r_z1sy);
            r_sz2  <= S1'(r_z1cy) - (S1'(r_xsy2) <<< FRAC_B);
            r_y1_3 <= r_y1_2;
        end
        if (w_en[4]) begin
            r_x2   <= $signed(n_rx[RW-1:FRAC_B]);
            r_z2   <= $signed(n_rz[RW-1:FRAC_B]);
            r_y1_4 <= r_y1_3;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[N-1];
    assign o_x2    = r_x2;
    assign o_z2    = r_z2;
    assign o_y1    = r_y1_4;

endmodule

// ===== design/erip_rot_z.sv =====
module erip_rot_z #(
    parameter int COORD_W = erip_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_B  = erip_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic signed [erip_pkg::x2_w(COORD_W, FRAC_B)-1:0] i_x2,
    input  logic signed [erip_pkg::x2_w(COORD_W, FRAC_B)-1:0] i_z2,
    input  logic signed [erip_pkg::y1_w(COORD_W)-1:0] i_y1,
    input  erip_pkg::t_coef                           i_coef,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic signed [erip_pkg::x3_w(COORD_W, FRAC_B)-1:0] o_x3,
    output logic signed [erip_pkg::x3_w(COORD_W, FRAC_B)-1:0] o_y3,
    output logic signed [erip_pkg::x2_w(COORD_W, FRAC_B)-1:0] o_z2
);
    import erip_pkg::*;

    localparam int N    = STG_Z;
    localparam int X2W  = x2_w(COORD_W, FRAC_B);
    localparam int Y1W  = y1_w(COORD_W);
    localparam int PXW  = X2W + COEF_W;
    localparam int PYW  = Y1W + COEF_W;
    localparam int S2N  = imax(PXW, PYW) + 1;
    localparam int S2W  = imin(S2N, 64);
    localparam int RW   = S2W + 1;
    localparam int X3W  = x3_w(COORD_W, FRAC_B);
    localparam longint HALF = longint'(1) <<< (FRAC_B - 1);

    logic [N-1:0] r_v;
    logic [N:0]   w_en;

    logic signed [PXW-1:0] r_x2cz, r_x2sz;
    logic signed [PYW-1:0] r_y1sz, r_y1cz;
    logic signed [S2W-1:0] r_sx3, r_sy3;
    logic signed [RW-1:0]  n_rx, n_ry;
    logic signed [X3W-1:0] r_x3, r_y3;
    logic signed [X2W-1:0] r_z2_0, r_z2_1, r_z2_2;

    always_comb begin
        w_en[N] = i_ready;
        for (int k = N - 1; k >= 0; k--) begin
            w_en[k] = ~r_v[k] | w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        n_rx = RW'(r_sx3) + RW'(HALF) - RW'({1'b0, r_sx3[S2W-1]});
        n_ry = RW'(r_sy3) + RW'(HALF) - RW'({1'b0, r_sy3[S2W-1]});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_x2cz <= PXW'(i_x2) * PXW'(i_coef.cos_z);
            r_x2sz <= PXW'(i_x2) * PXW'(i_coef.sin_z);
            r_y1sz <= PYW'(i_y1) * PYW'(i_coef.sin_z);
            r_y1cz <= PYW'(i_y1) * PYW'(i_coef.cos_z);
            r_z2_0 <= i_z2;
        end
        if (w_en[1]) begin
            // sums wrap at 64 bits
            r_sx3  <= S2W'(S2N'(r_x2cz) - S2N'(r_y1sz));
            r_sy3  <= S2W'(S2N'(r_x2sz) + S2N'(r_y1cz));
            r_z2_1 <= r_z2_0;
        end
        if (w_en[2]) begin
            r_x3   <= $signed(n_rx[RW-1:FRAC_B]);
            r_y3   <= $signed(n_ry[RW-1:FRAC_B]);
            r_z2_2 <= r_z2_1;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[N-1];
    assign o_x3    = r_x3;
    assign o_y3    = r_y3;
    assign o_z2    = r_z2_2;

endmodule

// ===== design/erip_proj.sv =====
module erip_proj #(
    parameter int COORD_W = erip_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_B  = erip_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic signed [erip_pkg::x3_w(COORD_W, FRAC_B)-1:0] i_x3,
    input  logic signed [erip_pkg::x3_w(COORD_W, FRAC_B)-1:0] i_y3,
    input  logic signed [erip_pkg::x2_w(COORD_W, FRAC_B)-1:0] i_z2,
    input  logic signed [erip_pkg::OFFS_W-1:0]        i_off_x,
    input  logic signed [erip_pkg::OFFS_W-1:0]        i_off_y,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic signed [erip_pkg::OUT_W-1:0]         o_px,
    output logic signed [erip_pkg::OUT_W-1:0]         o_py
);
    import erip_pkg::*;

    localparam int N    = STG_PROJ;
    localparam int X2W  = x2_w(COORD_W, FRAC_B);
    localparam int X3W  = x3_w(COORD_W, FRAC_B);
    localparam int DW   = X3W + 1;
    localparam int PW   = DW + FRAC_B + 1;
    localparam int AXW  = imin(PW, 64);
    localparam int S3N  = imax(PW, X2W + FRAC_B) + 1;
    localparam int AYW  = imin(S3N, 64);
    localparam int RXW  = AXW + 1;
    localparam int RYW  = AYW + 1;
    localparam int SH   = 2 * FRAC_B;
    localparam int QXW  = RXW - SH;
    localparam int QYW  = RYW - SH;
    localparam longint HALF = longint'(1) <<< (SH - 1);
    localparam logic signed [FRAC_B:0] KC = (FRAC_B + 1)'(const_frac(COS_HALF_Q32, FRAC_B));
    localparam logic signed [FRAC_B:0] KS = (FRAC_B + 1)'(const_frac(SIN_HALF_Q32, FRAC_B));

    logic [N-1:0] r_v;
    logic [N:0]   w_en;

    logic signed [DW-1:0]    r_dif, r_sum;
    logic signed [X2W-1:0]   r_z2_0, r_z2_1;
    logic signed [PW-1:0]    r_pdx, r_psy;
    logic signed [AXW-1:0]   r_ax;
    logic signed [AYW-1:0]   r_ay;
    logic signed [RXW-1:0]   n_rx;
    logic signed [RYW-1:0]   n_ry;
    logic signed [QXW-1:0]   r_qx;
    logic signed [QYW-1:0]   r_qy;
    logic signed [OUT_W-1:0] r_px, r_py;

    always_comb begin
        w_en[N] = i_ready;
        for (int k = N - 1; k >= 0; k--) begin
            w_en[k] = ~r_v[k] | w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        n_rx = RXW'(r_ax) + RXW'(HALF) - RXW'({1'b0, r_ax[AXW-1]});
        n_ry = RYW'(r_ay) + RYW'(HALF) - RYW'({1'b0, r_ay[AYW-1]});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_dif  <= DW'(i_x3) - DW'(i_y3);
            r_sum  <= DW'(i_x3) + DW'(i_y3);
            r_z2_0 <= i_z2;
        end
        if (w_en[1]) begin
            r_pdx  <= PW'(r_dif) * PW'(KC);
            r_psy  <= PW'(r_sum) * PW'(KS);
            r_z2_1 <= r_z2_0;
        end
        if (w_en[2]) begin
            r_ax <= AXW'(r_pdx);
            r_ay <= AYW'(S3N'(r_psy) - (S3N'(r_z2_1) <<< FRAC_B));
        end
        if (w_en[3]) begin
            r_qx <= $signed(n_rx[RXW-1:SH]);
            r_qy <= $signed(n_ry[RYW-1:SH]);
        end
        if (w_en[4]) begin
            r_px <= OUT_W'(r_qx) + OUT_W'(i_off_x);
            r_py <= OUT_W'(r_qy) + OUT_W'(i_off_y);
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[N-1];
    assign o_px    = r_px;
    assign o_py    = r_py;

endmodule

// ===== design/euler_rotate_isometric_project.sv =====
// Point transform: rotation about x, then y, then z, then isometric projection.
// Input channel i_in_valid / o_in_ready carries one point (i_point_x, _y, _z);
// output channel o_out_valid / i_out_ready carries the screen position
// (o_pixel_x, o_pixel_y). A transaction completes when valid and ready are
// both high at a rising edge of i_clk.
// Coefficients (Q2.14 by default) and screen offsets are written through
// i_cfg_we / i_cfg_idx / i_cfg_wdata, one register per cycle; the user must
// write them only while no point is in flight, the block does not enforce it.
// Five stages serve the x and y rotations, three the z rotation and five the
// projection, with a register after every multiply and every rounding add.
// Throughput is one point per cycle while the receiver takes results; each
// stage has its own valid bit and loads whenever it is empty or its successor
// moves, so bubbles close up. When the receiver stalls, the result holds in
// the last stage and points keep entering until every stage is full, then
// o_in_ready drops. Synchronous active-low reset empties the pipeline and
// sets rotations to identity and offsets to zero.
`include "euler_rotate_isometric_project_defines.svh"

module euler_rotate_isometric_project #(
    parameter int COORD_WIDTH    = erip_pkg::COORD_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = erip_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [erip_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [erip_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]         i_point_x,
    input  logic signed [COORD_WIDTH-1:0]         i_point_y,
    input  logic signed [COORD_WIDTH-1:0]         i_point_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [erip_pkg::OUT_W-1:0]     o_pixel_x,
    output logic signed [erip_pkg::OUT_W-1:0]     o_pixel_y
);
    import erip_pkg::*;

    localparam int Y1W = y1_w(COORD_WIDTH);
    localparam int X2W = x2_w(COORD_WIDTH, COEF_FRAC_BITS);
    localparam int X3W = x3_w(COORD_WIDTH, COEF_FRAC_BITS);
    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(longint'(1) <<< COEF_FRAC_BITS);

    t_coef                    r_coef;
    logic signed [OFFS_W-1:0] r_off_x, r_off_y;

    logic                  w_xy_valid, w_xy_ready;
    logic signed [X2W-1:0] w_x2, w_z2;
    logic signed [Y1W-1:0] w_y1;
    logic                  w_z_valid, w_z_ready;
    logic signed [X3W-1:0] w_x3, w_y3;
    logic signed [X2W-1:0] w_z2_d;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_in_acc, w_out_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.cos_x <= COEF_ONE;
            r_coef.sin_x <= '0;
            r_coef.cos_y <= COEF_ONE;
            r_coef.sin_y <= '0;
            r_coef.cos_z <= COEF_ONE;
            r_coef.sin_z <= '0;
            r_off_x      <= '0;
            r_off_y      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COS_X: r_coef.cos_x <= $signed(i_cfg_wdata[COEF_W-1:0]);
                REG_SIN_X: r_coef.sin_x <= $signed(i_cfg_wdata[COEF_W-1:0]);
                REG_COS_Y: r_coef.cos_y <= $signed(i_cfg_wdata[COEF_W-1:0]);
                REG_SIN_Y: r_coef.sin_y <= $signed(i_cfg_wdata[COEF_W-1:0]);
                REG_COS_Z: r_coef.cos_z <= $signed(i_cfg_wdata[COEF_W-1:0]);
                REG_SIN_Z: r_coef.sin_z <= $signed(i_cfg_wdata[COEF_W-1:0]);
                REG_OFF_X: r_off_x      <= $signed(i_cfg_wdata[OFFS_W-1:0]);
                REG_OFF_Y: r_off_y      <= $signed(i_cfg_wdata[OFFS_W-1:0]);
            endcase
        end
    end

    erip_rot_xy #(
        .COORD_W (COORD_WIDTH),
        .FRAC_B  (COEF_FRAC_BITS)
    ) u_rot_xy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .i_z     (i_point_z),
        .i_coef  (r_coef),
        .o_valid (w_xy_valid),
        .i_ready (w_xy_ready),
        .o_x2    (w_x2),
        .o_z2    (w_z2),
        .o_y1    (w_y1)
    );

    erip_rot_z #(
        .COORD_W (COORD_WIDTH),
        .FRAC_B  (COEF_FRAC_BITS)
    ) u_rot_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_xy_valid),
        .o_ready (w_xy_ready),
        .i_x2    (w_x2),
        .i_z2    (w_z2),
        .i_y1    (w_y1),
        .i_coef  (r_coef),
        .o_valid (w_z_valid),
        .i_ready (w_z_ready),
        .o_x3    (w_x3),
        .o_y3    (w_y3),
        .o_z2    (w_z2_d)
    );

    erip_proj #(
        .COORD_W (COORD_WIDTH),
        .FRAC_B  (COEF_FRAC_BITS)
    ) u_proj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_z_valid),
        .o_ready (w_z_ready),
        .i_x3    (w_x3),
        .i_y3    (w_y3),
        .i_z2    (w_z2_d),
        .i_off_x (r_off_x),
        .i_off_y (r_off_y),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_px    (o_pixel_x),
        .o_py    (o_pixel_y)
    );

    // points in flight
    assign w_in_acc  = i_in_valid & o_in_ready;
    assign w_out_acc = o_out_valid & i_out_ready;

    always_comb begin
        n_cnt = r_cnt + CNT_W'(w_in_acc) - CNT_W'(w_out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `ERIP_ASSERT_IMP(a_out_has_item, o_out_valid, r_cnt != '0, "result with no point in flight")
    `ERIP_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= CNT_W'(PIPE_DEPTH), "more points than stages")
    `ERIP_ASSERT_IMP(a_full_only_stalled, !o_in_ready, o_out_valid && !i_out_ready, "input blocked")
    `ERIP_ASSERT_NXT(a_empty_stays_quiet, r_cnt == '0 && !w_in_acc, !o_out_valid, "result from empty")

endmodule
